[rtl/rar_pkg.sv]
// Package for the rational fraction arithmetic block: widths, opcodes,
// sign/magnitude helpers and the microcode program of the sequencer.
// Depends on nothing; used by rtl/rational_arith_reduce.sv.
package rar_pkg;

	// Operand width of the numerator and denominator fields.
	localparam int OPERAND_WIDTH = 16;
	// Products and the cross-multiplied sum fit in twice the operand width.
	localparam int WIDE_W = 2 * OPERAND_WIDTH;
	localparam int KW = $clog2(WIDE_W);
	localparam int CW = $clog2(WIDE_W);
	localparam int NUM_OUT_W = 33;
	localparam int DEN_OUT_W = 31;
	// Working width for forming the signed result before it is cut to the ports.
	localparam int XW = (WIDE_W + 1 > NUM_OUT_W) ? WIDE_W + 1 : NUM_OUT_W;
	localparam int PC_W = 4;

	localparam logic [1:0] OP_ADD = 2'd0;
	localparam logic [1:0] OP_SUB = 2'd1;
	localparam logic [1:0] OP_MUL = 2'd2;
	localparam logic [1:0] OP_DIV = 2'd3;

	// Datapath actions.
	localparam logic [3:0] ACT_NOP          = 4'd0;
	localparam logic [3:0] ACT_LD_DEN       = 4'd1;
	localparam logic [3:0] ACT_LD_NUM       = 4'd2;
	localparam logic [3:0] ACT_ADD_NUM      = 4'd3;
	localparam logic [3:0] ACT_GCD_INIT     = 4'd4;
	localparam logic [3:0] ACT_GCD_STEP     = 4'd5;
	localparam logic [3:0] ACT_SHL_G        = 4'd6;
	localparam logic [3:0] ACT_DIV_INIT_NUM = 4'd7;
	localparam logic [3:0] ACT_DIV_STEP     = 4'd8;
	localparam logic [3:0] ACT_DIV_INIT_DEN = 4'd9;
	localparam logic [3:0] ACT_OUT_LOAD     = 4'd10;
	localparam logic [3:0] ACT_OUT_ERR      = 4'd11;

	// Multiplier operand pairs.
	localparam logic [1:0] M_NUM1 = 2'd0;
	localparam logic [1:0] M_NUM2 = 2'd1;
	localparam logic [1:0] M_DEN  = 2'd2;

	// Jump conditions.
	localparam logic [2:0] C_NEVER    = 3'd0;
	localparam logic [2:0] C_ALWAYS   = 3'd1;
	localparam logic [2:0] C_IDLE     = 3'd2;
	localparam logic [2:0] C_OP_MD    = 3'd3;
	localparam logic [2:0] C_DEN_ZERO = 3'd4;
	localparam logic [2:0] C_GCD_BUSY = 3'd5;
	localparam logic [2:0] C_K_NZ     = 3'd6;
	localparam logic [2:0] C_DIV_BUSY = 3'd7;

	// Step addresses of the program.
	localparam logic [PC_W-1:0] S_WAIT     = 4'd0;
	localparam logic [PC_W-1:0] S_MUL_DEN  = 4'd1;
	localparam logic [PC_W-1:0] S_MUL_N1   = 4'd2;
	localparam logic [PC_W-1:0] S_MUL_N2   = 4'd3;
	localparam logic [PC_W-1:0] S_ADD      = 4'd4;
	localparam logic [PC_W-1:0] S_GCD_INIT = 4'd5;
	localparam logic [PC_W-1:0] S_GCD      = 4'd6;
	localparam logic [PC_W-1:0] S_SHL      = 4'd7;
	localparam logic [PC_W-1:0] S_DIVN_INI = 4'd8;
	localparam logic [PC_W-1:0] S_DIVN     = 4'd9;
	localparam logic [PC_W-1:0] S_DIVD_INI = 4'd10;
	localparam logic [PC_W-1:0] S_DIVD     = 4'd11;
	localparam logic [PC_W-1:0] S_OUT      = 4'd12;
	localparam logic [PC_W-1:0] S_ERR      = 4'd13;

	typedef struct packed {
		logic            neg;
		logic [OPERAND_WIDTH-1:0] mag;
	} smag_t;

	typedef struct packed {
		logic [3:0]      act;
		logic [1:0]      msel;
		logic [2:0]      cond;
		logic [PC_W-1:0] target;
	} ctrl_t;

	// Two's complement to sign and magnitude; the most negative value maps to
	// its exact magnitude, which still fits the unsigned field.
	function automatic smag_t to_smag(input logic [OPERAND_WIDTH-1:0] raw);
		smag_t r;
		r.neg = raw[OPERAND_WIDTH-1];
		r.mag = r.neg ? (~raw + 1'b1) : raw;
		return r;
	endfunction

	function automatic ctrl_t cw(input logic [3:0] act, input logic [1:0] msel,
			input logic [2:0] cond, input logic [PC_W-1:0] target);
		ctrl_t c;
		c.act    = act;
		c.msel   = msel;
		c.cond   = cond;
		c.target = target;
		return c;
	endfunction

	// The program. A step jumps to its target when its condition holds and
	// otherwise falls through to the next step.
	function automatic ctrl_t ucode(input logic [PC_W-1:0] pc);
		ctrl_t c;
		unique case (pc)
			S_WAIT:     c = cw(ACT_NOP,          M_DEN,  C_IDLE,     S_WAIT);
			S_MUL_DEN:  c = cw(ACT_NOP,          M_DEN,  C_NEVER,    S_WAIT);
			S_MUL_N1:   c = cw(ACT_LD_DEN,       M_NUM1, C_NEVER,    S_WAIT);
			S_MUL_N2:   c = cw(ACT_LD_NUM,       M_NUM2, C_OP_MD,    S_GCD_INIT);
			S_ADD:      c = cw(ACT_ADD_NUM,      M_DEN,  C_NEVER,    S_WAIT);
			S_GCD_INIT: c = cw(ACT_GCD_INIT,     M_DEN,  C_DEN_ZERO, S_ERR);
			S_GCD:      c = cw(ACT_GCD_STEP,     M_DEN,  C_GCD_BUSY, S_GCD);
			S_SHL:      c = cw(ACT_SHL_G,        M_DEN,  C_K_NZ,     S_SHL);
			S_DIVN_INI: c = cw(ACT_DIV_INIT_NUM, M_DEN,  C_NEVER,    S_WAIT);
			S_DIVN:     c = cw(ACT_DIV_STEP,     M_DEN,  C_DIV_BUSY, S_DIVN);
			S_DIVD_INI: c = cw(ACT_DIV_INIT_DEN, M_DEN,  C_NEVER,    S_WAIT);
			S_DIVD:     c = cw(ACT_DIV_STEP,     M_DEN,  C_DIV_BUSY, S_DIVD);
			S_OUT:      c = cw(ACT_OUT_LOAD,     M_DEN,  C_ALWAYS,   S_WAIT);
			S_ERR:      c = cw(ACT_OUT_ERR,      M_DEN,  C_ALWAYS,   S_WAIT);
			default:    c = cw(ACT_NOP,          M_DEN,  C_ALWAYS,   S_WAIT);
		endcase
		return c;
	endfunction

endpackage

[rtl/rational_arith_reduce.sv]
// Top level of the rational fraction arithmetic block: a microcoded
// sequencer over one multiplier, a binary GCD unit and a bit-serial divider.
// Depends on rtl/rar_pkg.sv.

// The block takes two signed fractions a_num/a_den and b_num/b_den and an
// opcode (add, subtract, multiply, divide) in one input beat and returns one
// output beat: the result reduced to lowest terms with a positive
// denominator, the sign carried by res_num. When the unreduced denominator is
// zero, div_zero is set and the result reads 0/0. A numerator of zero gives
// 0/1. Work is done by a short program in a read-only table, one control
// word per clock unless the output step stalls, driving a shared multiplier,
// a binary GCD unit that does one subtract-and-halve per clock, and a
// restoring divider that produces one quotient bit per clock. After the
// accepting edge one item goes through the multiplication steps (with an
// extra add step for add and subtract), the GCD start, the GCD search, the
// steps that restore the common factors of two, the two divisions by the
// GCD over WIDE_W = 32 bits and the load of the output register. A zero raw
// denominator skips the reduction and goes straight to the error output.
// One item is in flight at a time; in_ready is high while the sequencer
// waits at its first step, and the next item is accepted while the previous
// result still waits in the output register for out_ready.
module rational_arith_reduce
	import rar_pkg::*;
(
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      opcode,
	input  logic signed [OPERAND_WIDTH-1:0] a_num,
	input  logic signed [OPERAND_WIDTH-1:0] a_den,
	input  logic signed [OPERAND_WIDTH-1:0] b_num,
	input  logic signed [OPERAND_WIDTH-1:0] b_den,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [NUM_OUT_W-1:0]     res_num,
	output logic [DEN_OUT_W-1:0]            res_den,
	output logic                            div_zero
);

	// Sequencer state.
	logic [PC_W-1:0] pc_q;
	ctrl_t           ctrl;
	logic            take;
	logic            hold;
	logic            out_free;
	logic            out_valid_q;

	// Operands, latched at the accepted input beat.
	logic [1:0] op_q;
	smag_t      an_q, ad_q, bn_q, bd_q;

	// Multiplier and working registers.
	smag_t              mx, my;
	logic [WIDE_W-1:0]  prod_q;
	logic               prod_neg_q;
	logic               num_neg_q, den_neg_q;
	logic [WIDE_W-1:0]  num_mag_q, den_mag_q;
	logic [WIDE_W-1:0]  u_q, v_q;
	logic [KW-1:0]      k_q;
	logic [WIDE_W-1:0]  rem_q, quo_q;
	logic [CW-1:0]      cnt_q;

	// Output register.
	logic signed [NUM_OUT_W-1:0] res_num_q;
	logic [DEN_OUT_W-1:0]        res_den_q;
	logic                        div_zero_q;

	logic              add_sign;
	logic              gcd_busy;
	logic [WIDE_W:0]   rem_sh;
	logic [WIDE_W:0]   rem_diff;
	logic              res_neg;
	logic [XW-1:0]     num_x;
	logic [XW-1:0]     den_x;

	assign ctrl     = ucode(pc_q);
	assign in_ready = (pc_q == S_WAIT);
	assign out_free = !out_valid_q || out_ready;
	// The output steps stall until the output register is free.
	assign hold     = ((ctrl.act == ACT_OUT_LOAD) || (ctrl.act == ACT_OUT_ERR)) && !out_free;
	assign gcd_busy = (u_q != '0) && (v_q != '0);

	always_comb begin
		case (ctrl.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_IDLE:     take = !in_valid;
			C_OP_MD:    take = (op_q == OP_MUL) || (op_q == OP_DIV);
			C_DEN_ZERO: take = (den_mag_q == '0);
			C_GCD_BUSY: take = gcd_busy;
			C_K_NZ:     take = (k_q != '0);
			C_DIV_BUSY: take = (cnt_q != CW'(WIDE_W - 1));
			default:    take = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_WAIT;
		end else if (!hold) begin
			pc_q <= take ? ctrl.target : pc_q + 1'b1;
		end
	end

	// Operand selection for the shared multiplier. Multiply takes a_num*b_num
	// for its numerator, divide takes a_den*b_num for its denominator.
	always_comb begin
		mx = ad_q;
		my = bd_q;
		case (ctrl.msel)
			M_NUM1: begin
				mx = an_q;
				my = (op_q == OP_MUL) ? bn_q : bd_q;
			end
			M_NUM2: begin
				mx = bn_q;
				my = ad_q;
			end
			M_DEN: begin
				mx = ad_q;
				my = (op_q == OP_DIV) ? bn_q : bd_q;
			end
			default: begin
				mx = ad_q;
				my = bd_q;
			end
		endcase
	end

	// Subtract adds the second cross product with its sign flipped.
	assign add_sign = prod_neg_q ^ (op_q == OP_SUB);

	// One restoring division step: shift in the next dividend bit and
	// subtract the divisor when it fits.
	assign rem_sh   = {rem_q, quo_q[WIDE_W-1]};
	assign rem_diff = rem_sh - {1'b0, u_q};

	// Final sign: negative only when the signs differ and the value is nonzero.
	assign res_neg = (num_neg_q != den_neg_q) && (num_mag_q != '0);
	assign num_x   = res_neg ? (XW'(0) - XW'(num_mag_q)) : XW'(num_mag_q);
	assign den_x   = XW'(quo_q);

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= opcode;
			an_q <= to_smag(a_num);
			ad_q <= to_smag(a_den);
			bn_q <= to_smag(b_num);
			bd_q <= to_smag(b_den);
		end

		prod_q     <= WIDE_W'(mx.mag) * WIDE_W'(my.mag);
		prod_neg_q <= mx.neg ^ my.neg;

		case (ctrl.act)
			ACT_LD_DEN: begin
				den_mag_q <= prod_q;
				den_neg_q <= prod_neg_q;
			end
			ACT_LD_NUM: begin
				num_mag_q <= prod_q;
				num_neg_q <= prod_neg_q;
			end
			ACT_ADD_NUM: begin
				if (num_neg_q == add_sign) begin
					num_mag_q <= num_mag_q + prod_q;
				end else if (num_mag_q >= prod_q) begin
					num_mag_q <= num_mag_q - prod_q;
				end else begin
					num_mag_q <= prod_q - num_mag_q;
					num_neg_q <= add_sign;
				end
			end
			ACT_GCD_INIT: begin
				u_q <= num_mag_q;
				v_q <= den_mag_q;
				k_q <= '0;
			end
			ACT_GCD_STEP: begin
				// Binary GCD; the result ends up in u_q with the common
				// factors of two counted in k_q.
				if (u_q == '0) begin
					u_q <= v_q;
				end else if (v_q == '0) begin
					u_q <= u_q;
				end else if (!u_q[0] && !v_q[0]) begin
					u_q <= u_q >> 1;
					v_q <= v_q >> 1;
					k_q <= k_q + 1'b1;
				end else if (!u_q[0]) begin
					u_q <= u_q >> 1;
				end else if (!v_q[0]) begin
					v_q <= v_q >> 1;
				end else if (u_q >= v_q) begin
					u_q <= (u_q - v_q) >> 1;
				end else begin
					v_q <= (v_q - u_q) >> 1;
				end
			end
			ACT_SHL_G: begin
				if (k_q != '0) begin
					u_q <= u_q << 1;
					k_q <= k_q - 1'b1;
				end
			end
			ACT_DIV_INIT_NUM: begin
				quo_q <= num_mag_q;
				rem_q <= '0;
				cnt_q <= '0;
			end
			ACT_DIV_STEP: begin
				cnt_q <= cnt_q + 1'b1;
				if (!rem_diff[WIDE_W]) begin
					rem_q <= rem_diff[WIDE_W-1:0];
					quo_q <= {quo_q[WIDE_W-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[WIDE_W-1:0];
					quo_q <= {quo_q[WIDE_W-2:0], 1'b0};
				end
			end
			ACT_DIV_INIT_DEN: begin
				num_mag_q <= quo_q;
				quo_q     <= den_mag_q;
				rem_q     <= '0;
				cnt_q     <= '0;
			end
			default: begin
			end
		endcase

		if (ctrl.act == ACT_OUT_LOAD && out_free) begin
			res_num_q  <= num_x[NUM_OUT_W-1:0];
			res_den_q  <= den_x[DEN_OUT_W-1:0];
			div_zero_q <= 1'b0;
		end else if (ctrl.act == ACT_OUT_ERR && out_free) begin
			res_num_q  <= '0;
			res_den_q  <= '0;
			div_zero_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((ctrl.act == ACT_OUT_LOAD || ctrl.act == ACT_OUT_ERR) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign res_num   = res_num_q;
	assign res_den   = res_den_q;
	assign div_zero  = div_zero_q;

	// An accepted beat starts the program, so the input side closes at once.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input still ready after accepting a beat");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && div_zero) |-> (res_num == '0 && res_den == '0))
		else $error("error result is not zero over zero");

	a_den_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !div_zero) |-> (res_den != '0))
		else $error("valid result with zero denominator");

	a_gcd_operands: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.act == ACT_GCD_STEP) |-> (u_q != '0 || v_q != '0))
		else $error("GCD running on two zero operands");

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.act == ACT_DIV_STEP) |-> (rem_q < u_q))
		else $error("divider remainder not below divisor");

endmodule

[bench/testbench.sv]
// Testbench for rational_arith_reduce: drives fraction pairs and opcodes and
// checks each reduced result against a predictor of its own.
// Depends on rtl/rar_pkg.sv and rtl/rational_arith_reduce.sv.
module testbench
	import rar_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Cycles with no beat on either channel before the run is declared hung.
	// The limit lies far above the slowest item and the long receiver hold-off,
	// so this leaves a wide margin.
	localparam int STUCK_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 400;
	localparam int SETTLE_CYCLES = 300;

	// One reduced fraction as it appears on the output ports.
	typedef struct {
		logic signed [NUM_OUT_W-1:0] num;
		logic [DEN_OUT_W-1:0]        den;
		logic                        dz;
	} fraction_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_ready;
	logic [1:0]                      opcode;
	logic signed [OPERAND_WIDTH-1:0] a_num;
	logic signed [OPERAND_WIDTH-1:0] a_den;
	logic signed [OPERAND_WIDTH-1:0] b_num;
	logic signed [OPERAND_WIDTH-1:0] b_den;
	logic                            out_valid;
	logic                            out_ready;
	logic signed [NUM_OUT_W-1:0]     res_num;
	logic [DEN_OUT_W-1:0]            res_den;
	logic                            div_zero;

	// Reduced fractions predicted for accepted input beats, oldest first.
	fraction_t expected_fractions[$];
	int        mismatch_count = 0;
	int        result_index = 0;
	int        stuck_cycles = 0;
	// When set, neither side idles: a long stretch of back-to-back beats.
	bit        burst_mode = 1'b0;
	// Request for one long receiver hold-off; the receiver clears it when done.
	bit        hold_request = 1'b0;

	rational_arith_reduce dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.a_num     (a_num),
		.a_den     (a_den),
		.b_num     (b_num),
		.b_den     (b_den),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_num   (res_num),
		.res_den   (res_den),
		.div_zero  (div_zero)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Predicts the reduced result of one operation. Everything is done in
	// 64-bit signed arithmetic, which holds every product and sum exactly for
	// 16-bit operands, so the sign and magnitude come straight from the values.
	function automatic fraction_t reduce_fraction(input logic [1:0] op,
			input logic signed [OPERAND_WIDTH-1:0] an,
			input logic signed [OPERAND_WIDTH-1:0] ad,
			input logic signed [OPERAND_WIDTH-1:0] bn,
			input logic signed [OPERAND_WIDTH-1:0] bd);
		fraction_t r;
		longint xa_n, xa_d, xb_n, xb_d;
		longint n, d, nm, dm, x, y, t;
		logic neg;
		xa_n = longint'(an);
		xa_d = longint'(ad);
		xb_n = longint'(bn);
		xb_d = longint'(bd);
		case (op)
			OP_ADD: begin
				n = xa_n * xb_d + xb_n * xa_d;
				d = xa_d * xb_d;
			end
			OP_SUB: begin
				n = xa_n * xb_d - xb_n * xa_d;
				d = xa_d * xb_d;
			end
			OP_MUL: begin
				n = xa_n * xb_n;
				d = xa_d * xb_d;
			end
			default: begin
				n = xa_n * xb_d;
				d = xa_d * xb_n;
			end
		endcase
		// A zero raw denominator reads as 0/0 with the error flag.
		if (d == 0) begin
			r.num = '0;
			r.den = '0;
			r.dz  = 1'b1;
			return r;
		end
		nm = (n < 0) ? -n : n;
		dm = (d < 0) ? -d : d;
		// Euclid; a zero numerator leaves the denominator as the divisor, so
		// the result comes out as 0/1.
		x = nm;
		y = dm;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		nm = nm / x;
		dm = dm / x;
		neg = ((n < 0) != (d < 0)) && (nm != 0);
		r.num = NUM_OUT_W'(neg ? -nm : nm);
		r.den = DEN_OUT_W'(dm);
		r.dz  = 1'b0;
		return r;
	endfunction

	// Draws one operand: full-range values half the time, with zeros, the extremes
	// and small values mixed in so that reductions and zero cases are common.
	function automatic int pick_operand();
		case ($urandom_range(9))
			0: return 0;
			1: begin
				case ($urandom_range(3))
					0: return -32768;
					1: return 32767;
					2: return -1;
					default: return 1;
				endcase
			end
			2, 3, 4: return int'($urandom_range(24)) - 12;
			default: return int'($urandom);
		endcase
	endfunction

	task automatic flag_mismatch(input string msg);
		$display("mismatch at result %0d: %s", result_index, msg);
		mismatch_count++;
	endtask

	// Offers one input beat and records the predicted result once it is
	// accepted. Valid is lowered only during an idle gap, so a beat that
	// follows immediately keeps valid high with a single assignment.
	task automatic offer_operands(input logic [1:0] op, input int an, input int ad,
			input int bn, input int bd);
		logic signed [OPERAND_WIDTH-1:0] van, vad, vbn, vbd;
		van = OPERAND_WIDTH'(an);
		vad = OPERAND_WIDTH'(ad);
		vbn = OPERAND_WIDTH'(bn);
		vbd = OPERAND_WIDTH'(bd);
		if (!burst_mode) begin
			while ($urandom_range(99) < 35) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		opcode   <= op;
		a_num    <= van;
		a_den    <= vad;
		b_num    <= vbn;
		b_den    <= vbd;
		do
			@(posedge clk);
		while (!in_ready);
		expected_fractions.push_back(reduce_fraction(op, van, vad, vbn, vbd));
	endtask

	// Receiver: takes output beats with random stalls, and on request holds
	// off for a long stretch so that the block fills up behind its output
	// register and stops taking input beats.
	initial begin : receiver
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				out_ready <= burst_mode || ($urandom_range(99) >= 35);
			end
		end
	end

	// Checks every accepted output beat against the oldest prediction.
	always @(posedge clk) begin : check_fraction
		fraction_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_fractions.size() == 0) begin
				flag_mismatch($sformatf("unexpected beat %0d/%0d dz=%b",
					res_num, res_den, div_zero));
			end else begin
				want = expected_fractions.pop_front();
				if (res_num !== want.num)
					flag_mismatch($sformatf("res_num got %0d want %0d", res_num, want.num));
				if (res_den !== want.den)
					flag_mismatch($sformatf("res_den got %0d want %0d", res_den, want.den));
				if (div_zero !== want.dz)
					flag_mismatch($sformatf("div_zero got %b want %b", div_zero, want.dz));
			end
			result_index++;
		end
	end

	// Watchdog: ends the run when no beat moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles >= STUCK_LIMIT) begin
			$display("** rational_arith_reduce: FAILED **");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Every opcode, the zero-denominator and zero-numerator cases, the most
	// negative operands and the largest result magnitudes.
	task automatic test_directed();
		offer_operands(OP_ADD, 1, 2, 1, 3);
		offer_operands(OP_SUB, 1, 2, 1, 3);
		offer_operands(OP_MUL, 2, 3, 9, 4);
		offer_operands(OP_DIV, 2, 3, 4, 9);
		// Zero raw denominator, by each route into it.
		offer_operands(OP_ADD, 5, 0, 3, 7);
		offer_operands(OP_MUL, 5, 7, 3, 0);
		offer_operands(OP_DIV, 5, 7, 0, 3);
		offer_operands(OP_SUB, 0, 0, 0, 0);
		// Zero numerator gives 0/1.
		offer_operands(OP_ADD, 0, 5, 0, -7);
		offer_operands(OP_MUL, 0, -3, 4, 5);
		offer_operands(OP_SUB, 3, 4, 6, 8);
		// Negative denominators force the sign flip.
		offer_operands(OP_MUL, 3, -4, 5, 6);
		offer_operands(OP_DIV, -1, -1, -1, -1);
		// Most negative operands and the extremes of the result fields.
		offer_operands(OP_ADD, -32768, 1, -32768, 1);
		offer_operands(OP_MUL, -32768, 1, -32768, 1);
		offer_operands(OP_DIV, -32768, 1, 1, -32768);
		offer_operands(OP_DIV, 1, -32768, -32768, 1);
		offer_operands(OP_ADD, -32768, -32768, -32768, -32768);
		offer_operands(OP_SUB, -32768, 32767, 32767, -32768);
		offer_operands(OP_ADD, 32767, -32768, 32767, -32767);
		// Large terms that cancel completely to 1/1, and a messy large sum.
		offer_operands(OP_MUL, 32749, 32719, 32719, 32749);
		offer_operands(OP_ADD, 32767, 32766, -32765, 32764);
		offer_operands(OP_SUB, 'h5555, 'hAAAA, 'hAAAA, 'h5555);
	endtask

	// Random operands and opcodes with both sides idling at random.
	task automatic test_random_traffic(input int count);
		repeat (count)
			offer_operands(2'($urandom_range(3)), pick_operand(), pick_operand(),
				pick_operand(), pick_operand());
	endtask

	// The same traffic with no idling at all on either side.
	task automatic test_back_to_back(input int count);
		burst_mode = 1'b1;
		test_random_traffic(count);
		burst_mode = 1'b0;
	endtask

	// The receiver holds off for a long stretch while the sender keeps
	// offering beats, so the block stalls its input until output resumes.
	task automatic test_output_stall(input int count);
		hold_request = 1'b1;
		burst_mode = 1'b1;
		test_random_traffic(count);
		burst_mode = 1'b0;
	endtask

	initial begin
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		opcode   <= OP_ADD;
		a_num    <= '0;
		a_den    <= '0;
		b_num    <= '0;
		b_den    <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_traffic(350);
		test_back_to_back(150);
		test_output_stall(20);
		test_random_traffic(160);

		// Drain: valid drops, then every predicted beat must arrive, and a
		// quiet stretch afterwards catches any extra output beat.
		in_valid <= 1'b0;
		while (expected_fractions.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("** rational_arith_reduce: PASSED **");
		else
			$display("** rational_arith_reduce: FAILED **");
		$finish;
	end

endmodule
